[rtl/assert_macros.svh]
// Assertion macros used by the decoder top level.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is held.
`define NBPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nbpd assertion failed");

// Implication checked on every rising clock edge, off while reset is held.
`define NBPD_ASSERT_IMPL(lbl, ante, cons) \
  `NBPD_ASSERT(lbl, (ante) |-> (cons))

`endif

[rtl/nbpd_pkg.sv]
// Package of the nibble bus packet decoder: sizes, codes and the
// request and status types between the top level and the flush engine.
package nbpd_pkg;

  localparam int PACKET_CAP        = 8192;
  localparam int STORE_DEPTH       = 512;
  localparam int MAX_GRAPHIC_BYTES = 128;

  localparam int IDX_W   = $clog2(PACKET_CAP + 1);
  localparam int ST_AW   = $clog2(STORE_DEPTH);
  localparam int REM_W   = $clog2(MAX_GRAPHIC_BYTES + 1);
  localparam int NIB_J_W = $clog2(2 * MAX_GRAPHIC_BYTES + 7);
  localparam int GAP_W   = 17;

  localparam logic [GAP_W-1:0] GAP_MAX   = 17'h1FFFF;
  localparam logic [15:0]      GAP_RESET  = 16'd2000;
  localparam logic [15:0]      IDLE_RESET = 16'd50000;

  localparam logic [1:0] KIND_CMD     = 2'd0;
  localparam logic [1:0] KIND_TEXT    = 2'd1;
  localparam logic [1:0] KIND_GFX_NEW = 2'd2;
  localparam logic [1:0] KIND_GFX_XOR = 2'd3;

  localparam logic [3:0] CODE_GRAPHIC = 4'h2;
  localparam logic [3:0] CODE_TEXT    = 4'h3;

  localparam logic REG_GAP  = 1'b0;
  localparam logic REG_IDLE = 1'b1;

  typedef struct packed {
    logic             start;
    logic             mode_cmd;
    logic             pairs;
    logic [IDX_W-1:0] len;
  } flush_req_t;

  typedef struct packed {
    logic busy;
  } flush_stat_t;

endpackage

[rtl/nbpd_nib_store.sv]
// Nibble store of the decoder: one write port, one registered read port.
// Uses nbpd_pkg for its depth and index width.
module nbpd_nib_store (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [nbpd_pkg::IDX_W-1:0] wr_idx_i,
  input  logic [3:0]                wr_nib_i,
  input  logic                      rd_en_i,
  input  logic [nbpd_pkg::IDX_W-1:0] rd_idx_i,
  output logic [3:0]                rd_nib_o
);

  logic [3:0] mem_q [nbpd_pkg::STORE_DEPTH];
  logic [3:0] rd_q;
  logic       rd_in_range_q;

  // Indices past the store are not kept; reading them gives zero.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_idx_i) < 32'(nbpd_pkg::STORE_DEPTH))) begin
      mem_q[nbpd_pkg::ST_AW'(wr_idx_i)] <= wr_nib_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q          <= mem_q[nbpd_pkg::ST_AW'(rd_idx_i)];
      rd_in_range_q <= 32'(rd_idx_i) < 32'(nbpd_pkg::STORE_DEPTH);
    end
  end

  assign rd_nib_o = rd_in_range_q ? rd_q : 4'h0;

endmodule

[rtl/nbpd_flush.sv]
// Flush engine: walks the stored nibbles of a finished packet one read at
// a time, latches command fields and emits result words. Uses nbpd_pkg.
module nbpd_flush (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nbpd_pkg::flush_req_t       req_i,
  output nbpd_pkg::flush_stat_t      stat_o,
  output logic                       rd_en_o,
  output logic [nbpd_pkg::IDX_W-1:0] rd_idx_o,
  input  logic [3:0]                 rd_nib_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [3:0]                 cmd_code_o,
  output logic [3:0]                 flag_bits_o,
  output logic [7:0]                 column_o,
  output logic [7:0]                 row_o,
  output logic [15:0]                data_word_o,
  output logic [1:0]                 byte_count_o,
  output logic                       last_o
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_RD   = 5'b00010,
    F_CAP  = 5'b00100,
    F_FORM = 5'b01000,
    F_OUT  = 5'b10000
  } fstate_e;

  typedef enum logic [1:0] {
    JOB_CMD  = 2'd0,
    JOB_TEXT = 2'd1,
    JOB_GFX  = 2'd2
  } job_e;

  fstate_e state_q, state_d;
  job_e    job_q, job_d;
  logic    halved_q, halved_d;
  logic [nbpd_pkg::NIB_J_W-1:0] j_q, j_d;
  logic [2:0] p_q, p_d;
  logic [2:0] need_q, need_d;
  logic [nbpd_pkg::REM_W-1:0] rem_q, rem_d;
  logic [3:0] buf_q [6];

  logic [3:0] sv_cmd_q, sv_cmd_d, sv_flags_q, sv_flags_d;
  logic [7:0] sv_col_q, sv_col_d, sv_row_q, sv_row_d;

  logic [1:0]  kind_q, kind_d;
  logic [15:0] word_q, word_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        last_q, last_d;

  logic                       halved_c;
  logic [nbpd_pkg::IDX_W-1:0] len_c, bytes_full_c;
  logic [nbpd_pkg::REM_W-1:0] bytes_c, rem_next_c;
  logic [7:0]                 row_c;

  always_comb begin
    halved_c = (req_i.len >= nbpd_pkg::IDX_W'(2)) && !req_i.len[0] && req_i.pairs;
    len_c    = halved_c ? (req_i.len >> 1) : req_i.len;
    bytes_full_c = len_c >> 1;
    if (32'(bytes_full_c) > 32'(nbpd_pkg::MAX_GRAPHIC_BYTES)) begin
      bytes_c = nbpd_pkg::REM_W'(nbpd_pkg::MAX_GRAPHIC_BYTES);
    end else begin
      bytes_c = nbpd_pkg::REM_W'(bytes_full_c);
    end
    rem_next_c = rem_q - nbpd_pkg::REM_W'(2);
    row_c = {buf_q[5], buf_q[4]};
    if (buf_q[1][0] && (row_c < 8'd4)) begin
      row_c = row_c + 8'd4;
    end
  end

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    halved_d = halved_q;
    j_d      = j_q;
    p_d      = p_q;
    need_d   = need_q;
    rem_d    = rem_q;
    sv_cmd_d   = sv_cmd_q;
    sv_flags_d = sv_flags_q;
    sv_col_d   = sv_col_q;
    sv_row_d   = sv_row_q;
    kind_d = kind_q;
    word_d = word_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    rd_en_o = 1'b0;

    case (state_q)
      F_IDLE: begin
        if (req_i.start) begin
          halved_d = halved_c;
          j_d      = '0;
          p_d      = '0;
          rem_d    = bytes_c;
          if (req_i.mode_cmd) begin
            if (len_c >= nbpd_pkg::IDX_W'(6)) begin
              job_d   = JOB_CMD;
              need_d  = 3'd6;
              state_d = F_RD;
            end
          end else if (len_c >= nbpd_pkg::IDX_W'(2)) begin
            if (sv_cmd_q == nbpd_pkg::CODE_TEXT) begin
              job_d   = JOB_TEXT;
              need_d  = 3'd2;
              state_d = F_RD;
            end else if (sv_cmd_q == nbpd_pkg::CODE_GRAPHIC) begin
              job_d   = JOB_GFX;
              need_d  = (bytes_c >= nbpd_pkg::REM_W'(2)) ? 3'd4 : 3'd2;
              state_d = F_RD;
            end
          end
        end
      end
      F_RD: begin
        rd_en_o = 1'b1;
        state_d = F_CAP;
      end
      F_CAP: begin
        j_d = j_q + 1'b1;
        p_d = p_q + 3'd1;
        state_d = (p_q == need_q - 3'd1) ? F_FORM : F_RD;
      end
      F_FORM: begin
        case (job_q)
          JOB_CMD: begin
            sv_cmd_d   = buf_q[0];
            sv_flags_d = buf_q[1];
            sv_col_d   = {buf_q[3], buf_q[2]};
            sv_row_d   = row_c;
            kind_d = nbpd_pkg::KIND_CMD;
            word_d = 16'h0000;
            cnt_d  = 2'd0;
            last_d = 1'b1;
          end
          JOB_TEXT: begin
            kind_d = nbpd_pkg::KIND_TEXT;
            word_d = {8'h00, buf_q[1], buf_q[0]};
            cnt_d  = 2'd1;
            last_d = 1'b1;
          end
          default: begin
            kind_d = sv_flags_q[3] ? nbpd_pkg::KIND_GFX_NEW : nbpd_pkg::KIND_GFX_XOR;
            if (need_q == 3'd4) begin
              word_d = {buf_q[2], buf_q[3], buf_q[0], buf_q[1]};
              cnt_d  = 2'd2;
            end else begin
              word_d = {8'h00, buf_q[0], buf_q[1]};
              cnt_d  = 2'd1;
            end
            last_d = rem_q <= nbpd_pkg::REM_W'(2);
          end
        endcase
        state_d = F_OUT;
      end
      F_OUT: begin
        if (!out_stall_i) begin
          if (last_q) begin
            state_d = F_IDLE;
          end else begin
            rem_d   = rem_next_c;
            need_d  = (rem_next_c >= nbpd_pkg::REM_W'(2)) ? 3'd4 : 3'd2;
            p_d     = '0;
            state_d = F_RD;
          end
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign rd_idx_o = halved_q ? nbpd_pkg::IDX_W'({j_q, 1'b0}) : nbpd_pkg::IDX_W'(j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      sv_cmd_q   <= '0;
      sv_flags_q <= '0;
      sv_col_q   <= '0;
      sv_row_q   <= '0;
    end else begin
      state_q    <= state_d;
      sv_cmd_q   <= sv_cmd_d;
      sv_flags_q <= sv_flags_d;
      sv_col_q   <= sv_col_d;
      sv_row_q   <= sv_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    halved_q <= halved_d;
    j_q      <= j_d;
    p_q      <= p_d;
    need_q   <= need_d;
    rem_q    <= rem_d;
    kind_q   <= kind_d;
    word_q   <= word_d;
    cnt_q    <= cnt_d;
    last_q   <= last_d;
    if (state_q == F_CAP) begin
      buf_q[p_q] <= rd_nib_i;
    end
  end

  assign stat_o.busy  = (state_q != F_IDLE);
  assign out_valid_o  = (state_q == F_OUT);
  assign kind_o       = kind_q;
  assign cmd_code_o   = sv_cmd_q;
  assign flag_bits_o  = sv_flags_q;
  assign column_o     = sv_col_q;
  assign row_o        = sv_row_q;
  assign data_word_o  = word_q;
  assign byte_count_o = cnt_q;
  assign last_o       = last_q;

endmodule

[rtl/nibble_bus_packet_decoder.sv]
// Top level of the nibble bus packet decoder: intake sequencer, timing,
// configuration port. Uses nbpd_pkg, nbpd_nib_store, nbpd_flush.
`include "assert_macros.svh"

// Each input word is a bus sample or an idle check with the microseconds
// since the previous word. A word with no flush passes through evaluate and
// commit back to idle, where the next word can be accepted, so in_stall_o is
// high from each acceptance until the sequencer is idle again. A word that
// ends a packet adds a flush: the sequencer waits in its flush state until
// the flush engine is no longer busy, so a flush that gives no result still
// passes through the flush state. The flush engine reads the store one nibble
// at a time through its read and capture states, then forms a result and
// offers it until it is taken: six nibbles for a command packet, two for
// text, and per graphic result four for two bytes or two for one.
// Intake stays stalled until the last result word of the packet is taken.
// The store is not cleared after reset; only nibbles of the current packet
// are ever read.
module nibble_bus_packet_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [6:0]  raw_sample_i,
  input  logic [15:0] elapsed_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  cmd_code_o,
  output logic [3:0]  flag_bits_o,
  output logic [7:0]  column_o,
  output logic [7:0]  row_o,
  output logic [15:0] data_word_o,
  output logic [1:0]  byte_count_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EVAL   = 4'b0010,
    S_FLUSH  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] gap_thr_q, idle_thr_q;

  // Latched input word.
  logic        cmd_q;
  logic [6:0]  raw_q;
  logic [15:0] el_q;

  logic                       mode_cmd_q, mode_cmd_d;
  logic                       active_q, active_d;
  logic [nbpd_pkg::GAP_W-1:0] gap_q, gap_d;
  logic [nbpd_pkg::IDX_W-1:0] cnt_q, cnt_d;
  logic                       pairs_q, pairs_d;
  logic [3:0]                 prev_q, prev_d;
  logic                       flushed_q, flushed_d;

  logic [nbpd_pkg::GAP_W:0]   gap_sum;
  logic [nbpd_pkg::GAP_W-1:0] gap_sat;
  logic [3:0]                 inv, nib;
  logic                       now_cmd;
  logic                       need_flush;
  logic [nbpd_pkg::IDX_W-1:0] base_cnt;
  logic                       base_pairs;
  logic                       store_wr;

  nbpd_pkg::flush_req_t  freq;
  nbpd_pkg::flush_stat_t fstat;
  logic                       rd_en;
  logic [nbpd_pkg::IDX_W-1:0] rd_idx;
  logic [3:0]                 rd_nib;

  // APB registers. Only bit 2 of the address selects, so any write lands
  // in one of the two registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_thr_q  <= nbpd_pkg::GAP_RESET;
      idle_thr_q <= nbpd_pkg::IDLE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == nbpd_pkg::REG_GAP) begin
        gap_thr_q <= pwdata[15:0];
      end else begin
        idle_thr_q <= pwdata[15:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == nbpd_pkg::REG_IDLE) ? {16'h0000, idle_thr_q}
                                                   : {16'h0000, gap_thr_q};

  // Sample decode: active-low data, bit order reversed; bit 6 low is command.
  assign inv     = ~raw_q[3:0];
  assign nib     = {inv[0], inv[1], inv[2], inv[3]};
  assign now_cmd = !raw_q[6];

  // The gap counter saturates rather than wraps.
  assign gap_sum = {1'b0, gap_q} + (nbpd_pkg::GAP_W + 1)'(el_q);
  assign gap_sat = (gap_sum > {1'b0, nbpd_pkg::GAP_MAX}) ? nbpd_pkg::GAP_MAX
                                                         : gap_sum[nbpd_pkg::GAP_W-1:0];

  always_comb begin
    if (!cmd_q) begin
      need_flush = active_q && ((gap_sat > nbpd_pkg::GAP_W'(gap_thr_q)) ||
                                (now_cmd != mode_cmd_q));
    end else begin
      need_flush = active_q && (gap_sat > nbpd_pkg::GAP_W'(idle_thr_q));
    end
  end

  // After a flush the new nibble starts a fresh packet.
  assign base_cnt   = flushed_q ? '0 : cnt_q;
  assign base_pairs = flushed_q ? 1'b1 : pairs_q;
  assign store_wr   = (state_q == S_COMMIT) && !cmd_q &&
                      (32'(base_cnt) < 32'(nbpd_pkg::PACKET_CAP));

  always_comb begin
    state_d    = state_q;
    mode_cmd_d = mode_cmd_q;
    active_d   = active_q;
    gap_d      = gap_q;
    cnt_d      = cnt_q;
    pairs_d    = pairs_q;
    prev_d     = prev_q;
    flushed_d  = flushed_q;
    freq.start    = 1'b0;
    freq.mode_cmd = mode_cmd_q;
    freq.pairs    = pairs_q;
    freq.len      = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        gap_d     = gap_sat;
        flushed_d = need_flush;
        if (need_flush && (cnt_q != '0)) begin
          freq.start = 1'b1;
          state_d    = S_FLUSH;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_FLUSH: begin
        if (!fstat.busy) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!cmd_q) begin
          mode_cmd_d = now_cmd;
          active_d   = 1'b1;
          gap_d      = '0;
          cnt_d      = base_cnt;
          pairs_d    = base_pairs;
          if (store_wr) begin
            if (base_cnt[0] && (nib != prev_q)) begin
              pairs_d = 1'b0;
            end
            prev_d = nib;
            cnt_d  = base_cnt + 1'b1;
          end
        end else if (flushed_q) begin
          active_d = 1'b0;
          cnt_d    = '0;
          pairs_d  = 1'b1;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_cmd_q <= 1'b1;
      active_q   <= 1'b0;
      gap_q      <= '0;
      cnt_q      <= '0;
      pairs_q    <= 1'b1;
      prev_q     <= 4'h0;
      flushed_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_cmd_q <= mode_cmd_d;
      active_q   <= active_d;
      gap_q      <= gap_d;
      cnt_q      <= cnt_d;
      pairs_q    <= pairs_d;
      prev_q     <= prev_d;
      flushed_q  <= flushed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      cmd_q <= command_i;
      raw_q <= raw_sample_i;
      el_q  <= elapsed_us_i;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  nbpd_nib_store u_store (
    .clk_i    (clk_i),
    .wr_en_i  (store_wr),
    .wr_idx_i (base_cnt),
    .wr_nib_i (nib),
    .rd_en_i  (rd_en),
    .rd_idx_i (rd_idx),
    .rd_nib_o (rd_nib)
  );

  nbpd_flush u_flush (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (freq),
    .stat_o       (fstat),
    .rd_en_o      (rd_en),
    .rd_idx_o     (rd_idx),
    .rd_nib_i     (rd_nib),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .cmd_code_o   (cmd_code_o),
    .flag_bits_o  (flag_bits_o),
    .column_o     (column_o),
    .row_o        (row_o),
    .data_word_o  (data_word_o),
    .byte_count_o (byte_count_o),
    .last_o       (last_o)
  );

  // The flush engine only runs while the sequencer waits on it.
  `NBPD_ASSERT_IMPL(a_flush_in_flush_state, fstat.busy, state_q == S_FLUSH)
  // Results are only offered while intake is held off.
  `NBPD_ASSERT_IMPL(a_out_while_stalled, out_valid_o, in_stall_o)
  // The packet never grows past its cap.
  `NBPD_ASSERT(a_count_capped, 32'(cnt_q) <= 32'(nbpd_pkg::PACKET_CAP))

endmodule
